FILE: design/stks_pkg.sv
// Package for the sorted triple key search unit.
// Holds widths, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package stks_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;

    // Key fields, packed state | rule | position
    localparam int STATE_W = 12;
    localparam int RULE_W  = 12;
    localparam int POS_W   = 8;
    localparam int KEY_W   = STATE_W + RULE_W + POS_W;

    // Configuration registers
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT  = 1'b1;

    // Interpolated guess: len * (2*state+1) / (2*count)
    localparam int MUL_B_W    = STATE_W + 1;
    localparam int PROD_W     = LEN_W + MUL_B_W;
    localparam int DEN_W      = CFG_W + 1;
    localparam int DIV_CYCLES = PROD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_GUESS,
        ST_PROBE,
        ST_RESULT
    } stks_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // write the key into the table
        logic search;     // latch key and lengths for a new search
        logic mul;        // form the guess numerator
        logic div_step;   // two quotient bits
        logic guess;      // clamp the guess and start the first read
        logic probe;      // compare one entry, narrow the range
    } stks_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic len_zero;   // effective table length is zero
        logic probe_done; // hit, or range exhausted
    } stks_status_t;

endpackage

`default_nettype wire

FILE: design/stks_ctrl.sv
// Controller for the sorted triple key search unit.
// Sequences accept, multiply, divide, guess and probe steps. Depends on stks_pkg.
`default_nettype none

module stks_ctrl
    import stks_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         command,
    input  wire stks_status_t status,
    output stks_cmd_t         cmd,
    output logic              busy,
    output logic              done
);

    stks_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   accept;
    logic                   div_last;

    assign accept   = start && (state_reg == ST_IDLE);
    assign div_last = (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));

    // State and divide counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_cnt_next = '0;
                if (accept && (command == CMD_SEARCH))
                begin
                    if (status.len_zero)
                        state_next = ST_RESULT;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                    state_next = ST_GUESS;
            end
            ST_GUESS:
            begin
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (status.probe_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept && (command == CMD_LOAD);
        cmd.search   = accept && (command == CMD_SEARCH);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.guess    = (state_reg == ST_GUESS);
        cmd.probe    = (state_reg == ST_PROBE);
        busy         = (state_reg != ST_IDLE);
        done         = (state_reg == ST_RESULT);
    end

endmodule

`default_nettype wire

FILE: design/stks_dp.sv
// Datapath for the sorted triple key search unit: config registers, key table,
// guess multiplier, two-bit-per-cycle divider and binary search probe logic.
// Depends on stks_pkg.
`default_nettype none

module stks_dp
    import stks_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [ADDR_W-1:0]    entry_index,
    input  wire logic [STATE_W-1:0]   key_state,
    input  wire logic [RULE_W-1:0]    key_rule,
    input  wire logic [POS_W-1:0]     key_position,
    input  wire stks_cmd_t            cmd,
    output stks_status_t              status,
    output logic                      found
);

    logic [CFG_W-1:0]     table_length_reg;
    logic [CFG_W-1:0]     state_count_reg;

    logic [KEY_W-1:0]     mem [TABLE_DEPTH];
    logic [KEY_W-1:0]     rdata_reg;
    logic [ADDR_W-1:0]    raddr;

    logic [KEY_W-1:0]     key_in;
    logic [LEN_W-1:0]     len_eff;
    logic [CFG_W-1:0]     cnt_eff;

    logic [KEY_W-1:0]     key_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [MUL_B_W-1:0]   odd_reg;

    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;

    logic [ADDR_W-1:0]    mid_reg;
    logic [LEN_W-1:0]     left_reg, right_reg;
    logic [LEN_W-1:0]     left_new, right_new;
    logic [ADDR_W-1:0]    guess;
    logic [ADDR_W-1:0]    mid_next;
    logic [LEN_W:0]       range_sum;
    logic                 key_eq, key_gt, exhausted;
    logic                 found_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
            state_count_reg  <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TABLE_LENGTH: table_length_reg <= cfg_data;
                REG_STATE_COUNT:  state_count_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective length and state count
    always_comb
    begin
        if (table_length_reg > CFG_W'(TABLE_DEPTH))
            len_eff = LEN_W'(TABLE_DEPTH);
        else
            len_eff = LEN_W'(table_length_reg);
        cnt_eff = (state_count_reg == '0) ? CFG_W'(1) : state_count_reg;
    end

    assign key_in          = {key_state, key_rule, key_position};
    assign status.len_zero = (len_eff == '0);

    // Search operands, latched at accept
    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            key_reg <= key_in;
            len_reg <= len_eff;
            den_reg <= {cnt_eff, 1'b0};
            odd_reg <= {key_state, 1'b1};
        end
    end

    // Restoring divider, two quotient bits per cycle
    always_comb
    begin
        logic [DEN_W:0]    shifted;
        logic [DEN_W-1:0]  rem_t;
        logic [PROD_W-1:0] quo_t;
        rem_t = rem_reg;
        quo_t = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            shifted = {rem_t, quo_t[PROD_W-1]};
            quo_t   = {quo_t[PROD_W-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                shifted  = shifted - {1'b0, den_reg};
                quo_t[0] = 1'b1;
            end
            rem_t = shifted[DEN_W-1:0];
        end
        rem_next = rem_t;
        quo_next = quo_t;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            rem_reg <= '0;
            quo_reg <= len_reg * odd_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Clamp the guess into the table
    always_comb
    begin
        logic [LEN_W-1:0] last;
        last = len_reg - 1'b1;
        if (quo_reg >= PROD_W'(len_reg))
            guess = last[ADDR_W-1:0];
        else
            guess = quo_reg[ADDR_W-1:0];
    end

    // Probe compare and range update
    always_comb
    begin
        key_eq    = (key_reg == rdata_reg);
        key_gt    = (key_reg > rdata_reg);
        left_new  = key_gt ? (LEN_W'(mid_reg) + 1'b1) : left_reg;
        right_new = key_gt ? right_reg : LEN_W'(mid_reg);
        exhausted = (left_new >= right_new);
        range_sum = {1'b0, left_new} + {1'b0, right_new};
        mid_next  = range_sum[ADDR_W:1];
    end

    assign status.probe_done = key_eq || exhausted;
    assign raddr             = cmd.guess ? guess : mid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.guess)
        begin
            mid_reg   <= guess;
            left_reg  <= '0;
            right_reg <= len_reg;
        end
        else if (cmd.probe)
        begin
            mid_reg   <= mid_next;
            left_reg  <= left_new;
            right_reg <= right_new;
        end
    end

    // Key table: one write port for loads, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[entry_index] <= key_in;
        rdata_reg <= mem[raddr];
    end

    // Result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.search)
            found_reg <= 1'b0;
        else if (cmd.probe && status.probe_done)
            found_reg <= key_eq;
    end

    assign found = found_reg;

endmodule

`default_nettype wire

FILE: design/sorted_triple_key_search_unit.sv
// Top level of the sorted triple key search unit.
// Joins stks_ctrl and stks_dp. Depends on stks_pkg.
//
// Usage:
//   Transactions enter on start while busy is low. command = 0 loads the key
//   (key_state, key_rule, key_position) into table entry entry_index in the
//   accept cycle; busy stays low and no result follows.
//   command = 1 searches the first table_length entries, which software has
//   loaded in ascending (state, rule, position) order.
//   A search raises busy from the next cycle on; its result is found, shown
//   with done for exactly one cycle, and the receiver cannot stall it.
//   A search runs a multiply step, the divide steps for the interpolated first
//   guess (two quotient bits per cycle), a guess step, then probe steps (one
//   table read per cycle on the single table read port), then the done cycle.
//   An empty table answers found = 0, done right after accept. One search
//   at a time. Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 = table_length, 1 = state_count); the user must write only while the
//   unit is idle, which the unit does not enforce. Reset clears busy, done,
//   table_length = 0 and state_count = 1; the table contents are undefined
//   until loaded.
`default_nettype none

module sorted_triple_key_search_unit
    import stks_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 command,
    input  wire logic [ADDR_W-1:0]    entry_index,
    input  wire logic [STATE_W-1:0]   key_state,
    input  wire logic [RULE_W-1:0]    key_rule,
    input  wire logic [POS_W-1:0]     key_position,
    output logic                      done,
    output logic                      found
);

    stks_cmd_t    cmd;
    stks_status_t status;

    stks_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    stks_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry_index  (entry_index),
        .key_state    (key_state),
        .key_rule     (key_rule),
        .key_position (key_position),
        .cmd          (cmd),
        .status       (status),
        .found        (found)
    );

endmodule

`default_nettype wire

FILE: design/stks_chk.sv
// Port-level checker for the sorted triple key search unit, with its bind.
// Depends on stks_pkg and sorted_triple_key_search_unit.
`default_nettype none

module stks_chk
    import stks_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic command,
    input wire logic done
);

    // A result only shows while a search is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted search occupies the unit
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_SEARCH)) |=> busy)
        else $error("search accepted but unit not busy");

    // A load transaction completes at once with no result
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_LOAD)) |=> (!busy && !done))
        else $error("load transaction left unit busy");

    // The unit goes idle only right after a result
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

endmodule

bind sorted_triple_key_search_unit stks_chk u_stks_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done)
);

`default_nettype wire
